### hdl/wpg_pkg.sv
`timescale 1ns / 1ps
// wpg_pkg: shared types, codes and helper functions for the waypoint guidance core
// no dependencies; imported by every module of the block but wpg_ram

package wpg_pkg;

	// table depth default
	localparam int WAYPOINTS_DEF = 64;

	// result saturation limits
	localparam logic signed [65:0] SAT_HI = 66'sd8388607;
	localparam logic signed [65:0] SAT_LO = -66'sd8388608;

	// configuration reset values
	localparam logic [15:0]        XY_GAIN_RST   = 16'd64;
	localparam logic [15:0]        VERT_GAIN_RST = 16'd64;
	localparam logic [15:0]        HEAD_GAIN_RST = 16'd128;
	localparam logic signed [15:0] COS_RST       = 16'sd16384;
	localparam logic signed [15:0] SIN_RST       = 16'sd0;
	localparam logic [31:0]        RADIUS_RST    = 32'd10000;
	localparam logic [15:0]        DWELL_RST     = 16'd50;
	localparam logic [6:0]         WP_COUNT_RST  = 7'd1;

	typedef enum logic [1:0] {
		CMD_LOAD   = 2'd0,
		CMD_START  = 2'd1,
		CMD_SAMPLE = 2'd2,
		CMD_NONE   = 2'd3
	} wpg_cmd_t;

	typedef enum logic [2:0] {
		REG_XY_GAIN   = 3'd0,
		REG_VERT_GAIN = 3'd1,
		REG_HEAD_GAIN = 3'd2,
		REG_COS       = 3'd3,
		REG_SIN       = 3'd4,
		REG_RADIUS    = 3'd5,
		REG_DWELL     = 3'd6,
		REG_WP_COUNT  = 3'd7
	} wpg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ADVANCE,
		ST_READ,
		ST_DIFF,
		ST_CALC,
		ST_FINISH
	} wpg_state_t;

	// one multiply per step; the drain step only retires the last product
	typedef enum logic [3:0] {
		STEP_SQ_X  = 4'd0,
		STEP_SQ_Y  = 4'd1,
		STEP_SQ_Z  = 4'd2,
		STEP_UP    = 4'd3,
		STEP_YAW   = 4'd4,
		STEP_XC    = 4'd5,
		STEP_YS    = 4'd6,
		STEP_XS    = 4'd7,
		STEP_YC    = 4'd8,
		STEP_EAST  = 4'd9,
		STEP_NORTH = 4'd10,
		STEP_DRAIN = 4'd11
	} wpg_step_t;

	typedef struct packed {
		logic      capture;
		logic      load_diff;
		logic      mul_en;
		wpg_step_t step;
	} wpg_dp_ctl_t;

	function automatic logic signed [23:0] sat24(input logic signed [65:0] v);
		if (v > SAT_HI)
			return 24'sh7FFFFF;
		else if (v < SAT_LO)
			return $signed(24'h800000);
		else
			return v[23:0];
	endfunction

endpackage

### hdl/wpg_ram.sv
`timescale 1ns / 1ps
// wpg_ram: generic single write, single read memory with registered read data
// no dependencies

module wpg_ram #(
	parameter int WIDTH = 72,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		if (re)
			rdata <= mem_q[raddr];
	end

endmodule

### hdl/wpg_datapath.sv
`timescale 1ns / 1ps
// wpg_datapath: error forming, one shared signed multiplier, accumulator and result registers
// depends on wpg_pkg

module wpg_datapath (
	input  logic                      clk,
	input  logic                      arst_n,
	input  wpg_pkg::wpg_dp_ctl_t      ctl,
	input  logic signed [23:0]        pos_x,
	input  logic signed [23:0]        pos_y,
	input  logic signed [23:0]        pos_z,
	input  logic [12:0]               heading,
	input  logic signed [23:0]        way_x,
	input  logic signed [23:0]        way_y,
	input  logic signed [23:0]        way_z,
	input  logic [15:0]               xy_gain,
	input  logic [15:0]               vertical_gain,
	input  logic [15:0]               heading_gain,
	input  logic signed [15:0]        datum_cosine,
	input  logic signed [15:0]        datum_sine,
	input  logic [31:0]               arrive_radius_sq,
	output logic signed [23:0]        east_cmd,
	output logic signed [23:0]        north_cmd,
	output logic signed [23:0]        up_cmd,
	output logic signed [23:0]        yaw_rate_cmd,
	output logic                      in_radius
);

	import wpg_pkg::*;

	logic signed [23:0] px_q, py_q, pz_q;
	logic [12:0]        hd_q;
	logic signed [24:0] dx_q, dy_q, dz_q;
	logic signed [40:0] op_a;
	logic signed [24:0] op_b;
	logic signed [65:0] prod_s1;
	wpg_step_t          step_s1;
	logic               post_s1;
	logic signed [51:0] acc_q;
	logic signed [40:0] rot_q;
	logic signed [65:0] rnd8, rnd22;
	logic               in_radius_q;
	logic signed [23:0] east_q, north_q, up_q, yaw_q;

	// operand select for the shared multiplier
	always_comb begin
		op_a = 41'sd0;
		op_b = 25'sd0;
		case (ctl.step)
			STEP_SQ_X: begin
				op_a = 41'(dx_q);
				op_b = dx_q;
			end
			STEP_SQ_Y: begin
				op_a = 41'(dy_q);
				op_b = dy_q;
			end
			STEP_SQ_Z: begin
				op_a = 41'(dz_q);
				op_b = dz_q;
			end
			STEP_UP: begin
				op_a = 41'(dz_q);
				op_b = $signed({9'd0, vertical_gain});
			end
			STEP_YAW: begin
				op_a = 41'sd0 - $signed({28'd0, hd_q});
				op_b = $signed({9'd0, heading_gain});
			end
			STEP_XC: begin
				op_a = 41'(dx_q);
				op_b = 25'(datum_cosine);
			end
			STEP_YS: begin
				op_a = 41'(dy_q);
				op_b = 25'(datum_sine);
			end
			STEP_XS: begin
				op_a = 41'(dx_q);
				op_b = 25'(datum_sine);
			end
			STEP_YC: begin
				op_a = 41'(dy_q);
				op_b = 25'(datum_cosine);
			end
			STEP_EAST: begin
				op_a = rot_q;
				op_b = $signed({9'd0, xy_gain});
			end
			STEP_NORTH: begin
				op_a = acc_q[40:0];
				op_b = $signed({9'd0, xy_gain});
			end
			default: begin
				op_a = 41'sd0;
				op_b = 25'sd0;
			end
		endcase
	end

	// round half up at the two output scalings
	assign rnd8  = (prod_s1 + 66'sd128) >>> 8;
	assign rnd22 = (prod_s1 + 66'sd2097152) >>> 22;

	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			px_q <= pos_x;
			py_q <= pos_y;
			pz_q <= pos_z;
			hd_q <= heading;
		end
		if (ctl.load_diff) begin
			dx_q <= 25'(way_x) - 25'(px_q);
			dy_q <= 25'(way_y) - 25'(py_q);
			dz_q <= 25'(way_z) - 25'(pz_q);
		end
		if (ctl.mul_en) begin
			prod_s1 <= op_a * op_b;
			step_s1 <= ctl.step;
		end
		if (post_s1) begin
			case (step_s1) inside
				STEP_SQ_X, STEP_XC: acc_q <= 52'(prod_s1);
				STEP_SQ_Y, STEP_SQ_Z, STEP_YC: acc_q <= acc_q + 52'(prod_s1);
				STEP_YS: acc_q <= acc_q - 52'(prod_s1);
				STEP_XS: begin
					// park the east rotation, start the north one
					rot_q <= acc_q[40:0];
					acc_q <= 52'(prod_s1);
				end
				STEP_UP: begin
					up_q <= sat24(rnd8);
					// accumulator still holds the squared distance here
					in_radius_q <= $unsigned(acc_q) < {20'd0, arrive_radius_sq};
				end
				STEP_YAW:   yaw_q   <= sat24(rnd8);
				STEP_EAST:  east_q  <= sat24(rnd22);
				STEP_NORTH: north_q <= sat24(rnd22);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			post_s1 <= 1'b0;
		end else begin
			post_s1 <= ctl.mul_en;
		end
	end

	assign east_cmd     = east_q;
	assign north_cmd    = north_q;
	assign up_cmd       = up_q;
	assign yaw_rate_cmd = yaw_q;
	assign in_radius    = in_radius_q;

endmodule

### hdl/wpg_ctrl.sv
`timescale 1ns / 1ps
// wpg_ctrl: command decode, step sequencer and mission state (phase, dwell, finish)
// depends on wpg_pkg

module wpg_ctrl #(
	parameter int WAYPOINTS = wpg_pkg::WAYPOINTS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [1:0]           cmd,
	input  logic [15:0]          dwell_ticks,
	input  logic [6:0]           waypoint_count,
	input  logic                 in_radius,
	output logic                 busy,
	output logic                 ram_re,
	output logic [6:0]           phase,
	output wpg_pkg::wpg_dp_ctl_t dp_ctl,
	output logic                 result_valid,
	output logic [6:0]           current_phase,
	output logic                 done_res
);

	import wpg_pkg::*;

	wpg_state_t state_q, state_nx;
	wpg_step_t  step_q;
	logic       running_q, finished_q, arrived_q;
	logic [6:0] phase_q, plan_n;
	logic [15:0] dwell_q;
	logic       valid_q, done_q;
	logic [6:0] phase_out_q;
	logic       accept, go_sample;
	logic       arrived_nx, finished_nx;
	logic [15:0] dwell_nx;

	assign accept    = start && (state_q == ST_IDLE);
	assign go_sample = accept && (wpg_cmd_t'(cmd) == CMD_SAMPLE) && running_q && !finished_q;

	// plan size clamped to the table; a count of zero is taken as one
	always_comb begin
		if (waypoint_count == 7'd0)
			plan_n = 7'd1;
		else if (32'(waypoint_count) > 32'(WAYPOINTS))
			plan_n = 7'(WAYPOINTS);
		else
			plan_n = waypoint_count;
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE:    if (go_sample) state_nx = ST_ADVANCE;
			ST_ADVANCE: state_nx = ST_READ;
			ST_READ:    state_nx = ST_DIFF;
			ST_DIFF:    state_nx = ST_CALC;
			ST_CALC:    if (step_q == STEP_DRAIN) state_nx = ST_FINISH;
			ST_FINISH:  state_nx = ST_IDLE;
			default:    state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		busy             = state_q != ST_IDLE;
		ram_re           = state_q == ST_READ;
		dp_ctl.capture   = accept && (wpg_cmd_t'(cmd) == CMD_SAMPLE);
		dp_ctl.load_diff = state_q == ST_DIFF;
		dp_ctl.mul_en    = (state_q == ST_CALC) && (step_q != STEP_DRAIN);
		dp_ctl.step      = step_q;
	end

	// arrival and dwell update at the end of a sample
	always_comb begin
		arrived_nx  = arrived_q;
		dwell_nx    = dwell_q;
		finished_nx = finished_q;
		if (in_radius) begin
			if (!arrived_q) begin
				arrived_nx = 1'b1;
				dwell_nx   = 16'd0;
			end else if (dwell_q != 16'hFFFF) begin
				dwell_nx = dwell_q + 16'd1;
			end
			if (phase_q >= plan_n && dwell_nx > dwell_ticks)
				finished_nx = 1'b1;
		end else begin
			arrived_nx = 1'b0;
			dwell_nx   = 16'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= STEP_SQ_X;
			running_q   <= 1'b0;
			finished_q  <= 1'b0;
			arrived_q   <= 1'b0;
			phase_q     <= 7'd0;
			dwell_q     <= 16'd0;
			valid_q     <= 1'b0;
			done_q      <= 1'b0;
			phase_out_q <= 7'd0;
		end else begin
			state_q <= state_nx;
			valid_q <= 1'b0;
			if (accept && wpg_cmd_t'(cmd) == CMD_START) begin
				running_q  <= 1'b1;
				finished_q <= 1'b0;
				phase_q    <= 7'd1;
				arrived_q  <= 1'b0;
				dwell_q    <= 16'd0;
			end
			if (state_q == ST_ADVANCE && dwell_q > dwell_ticks && phase_q < plan_n) begin
				phase_q   <= phase_q + 7'd1;
				arrived_q <= 1'b0;
				dwell_q   <= 16'd0;
			end
			if (state_q == ST_DIFF)
				step_q <= STEP_SQ_X;
			else if (state_q == ST_CALC && step_q != STEP_DRAIN)
				step_q <= wpg_step_t'(step_q + 4'd1);
			if (state_q == ST_FINISH) begin
				arrived_q   <= arrived_nx;
				dwell_q     <= dwell_nx;
				finished_q  <= finished_nx;
				valid_q     <= 1'b1;
				phase_out_q <= phase_q;
				done_q      <= finished_nx;
			end
		end
	end

	assign phase         = phase_q;
	assign result_valid  = valid_q;
	assign current_phase = phase_out_q;
	assign done_res      = done_q;

endmodule

### hdl/waypoint_proportional_guidance_core.sv
`timescale 1ns / 1ps
// waypoint_proportional_guidance_core: result_valid strobes in the cycle that busy drops;
// a sample passes the idle accept cycle, the advance, table read and error cycles, the shared
// multiplier's 11 steps, its drain cycle and the finish cycle; no new sample is taken while busy.
// load and start never make the core busy and give no result.
// arst_n clears mission state and returns config registers to their reset values; the waypoint table is not cleared.
// the receiver cannot stall: each result is held on the ports for its one strobe cycle

module waypoint_proportional_guidance_core #(
	parameter int WAYPOINTS = wpg_pkg::WAYPOINTS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	// command channel
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         cmd,
	input  logic [5:0]         wp_index,
	input  logic signed [23:0] pos_x,
	input  logic signed [23:0] pos_y,
	input  logic signed [23:0] pos_z,
	input  logic [12:0]        heading,
	// configuration write port
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	// results
	output logic               result_valid,
	output logic signed [23:0] east_cmd,
	output logic signed [23:0] north_cmd,
	output logic signed [23:0] up_cmd,
	output logic signed [23:0] yaw_rate_cmd,
	output logic [6:0]         current_phase,
	output logic               done_res
);

	import wpg_pkg::*;

	localparam int AW = $clog2(WAYPOINTS);

	// configuration registers
	logic [15:0]        xy_gain_q, vert_gain_q, head_gain_q, dwell_q;
	logic signed [15:0] cos_q, sin_q;
	logic [31:0]        radius_q;
	logic [6:0]         wp_count_q;

	// table and sequencer wiring
	logic               ram_we, ram_re;
	logic [AW+5:0]      waddr_wide;
	logic [AW+6:0]      raddr_wide;
	logic [AW-1:0]      ram_waddr, ram_raddr;
	logic [71:0]        ram_rdata;
	logic [6:0]         phase;
	logic               in_radius;
	logic               slot_ok;
	wpg_dp_ctl_t        dp_ctl;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xy_gain_q   <= XY_GAIN_RST;
			vert_gain_q <= VERT_GAIN_RST;
			head_gain_q <= HEAD_GAIN_RST;
			cos_q       <= COS_RST;
			sin_q       <= SIN_RST;
			radius_q    <= RADIUS_RST;
			dwell_q     <= DWELL_RST;
			wp_count_q  <= WP_COUNT_RST;
		end else if (cfg_we) begin
			unique case (wpg_reg_t'(cfg_index))
				REG_XY_GAIN:   xy_gain_q   <= cfg_data[15:0];
				REG_VERT_GAIN: vert_gain_q <= cfg_data[15:0];
				REG_HEAD_GAIN: head_gain_q <= cfg_data[15:0];
				REG_COS:       cos_q       <= $signed(cfg_data[15:0]);
				REG_SIN:       sin_q       <= $signed(cfg_data[15:0]);
				REG_RADIUS:    radius_q    <= cfg_data;
				REG_DWELL:     dwell_q     <= cfg_data[15:0];
				REG_WP_COUNT:  wp_count_q  <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	// load transfers write straight into the table; slots past the depth are dropped
	assign slot_ok    = {26'd0, wp_index} < 32'(WAYPOINTS);
	assign ram_we     = start && !busy && (wpg_cmd_t'(cmd) == CMD_LOAD) && slot_ok;
	assign waddr_wide = {{AW{1'b0}}, wp_index};
	assign ram_waddr  = waddr_wide[AW-1:0];

	// current waypoint is entry phase - 1; phase is never zero during a sample
	assign raddr_wide = {{AW{1'b0}}, phase - 7'd1};
	assign ram_raddr  = raddr_wide[AW-1:0];

	wpg_ram #(
		.WIDTH (72),
		.DEPTH (WAYPOINTS)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata ({pos_x, pos_y, pos_z}),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// sequencer: advance check, table read, error forming, multiply steps, dwell update
	wpg_ctrl #(
		.WAYPOINTS (WAYPOINTS)
	) u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.cmd            (cmd),
		.dwell_ticks    (dwell_q),
		.waypoint_count (wp_count_q),
		.in_radius      (in_radius),
		.busy           (busy),
		.ram_re         (ram_re),
		.phase          (phase),
		.dp_ctl         (dp_ctl),
		.result_valid   (result_valid),
		.current_phase  (current_phase),
		.done_res       (done_res)
	);

	// shared multiplier: squared distance, rotation, gains and saturation
	wpg_datapath u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.ctl              (dp_ctl),
		.pos_x            (pos_x),
		.pos_y            (pos_y),
		.pos_z            (pos_z),
		.heading          (heading),
		.way_x            ($signed(ram_rdata[71:48])),
		.way_y            ($signed(ram_rdata[47:24])),
		.way_z            ($signed(ram_rdata[23:0])),
		.xy_gain          (xy_gain_q),
		.vertical_gain    (vert_gain_q),
		.heading_gain     (head_gain_q),
		.datum_cosine     (cos_q),
		.datum_sine       (sin_q),
		.arrive_radius_sq (radius_q),
		.east_cmd         (east_cmd),
		.north_cmd        (north_cmd),
		.up_cmd           (up_cmd),
		.yaw_rate_cmd     (yaw_rate_cmd),
		.in_radius        (in_radius)
	);

endmodule

### hdl/wpg_checker.sv
`timescale 1ns / 1ps
// wpg_checker: port-level checks on the guidance core's command and result timing
// depends on wpg_pkg; bound to waypoint_proportional_guidance_core below

module wpg_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic [1:0] cmd,
	input logic       result_valid,
	input logic [6:0] current_phase
);

	import wpg_pkg::*;

	// one result per sample, never back to back
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid)
		else $error("result strobe held for two cycles");

	// result appears as the core goes idle
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !busy && $past(busy))
		else $error("result strobe outside end of sample");

	// a result always names a real phase
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> current_phase != 7'd0)
		else $error("result with phase zero");

	// load, start and unused commands never make the core busy
	assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && wpg_cmd_t'(cmd) != CMD_SAMPLE) |=> !busy)
		else $error("non-sample transfer made the core busy");

endmodule

bind waypoint_proportional_guidance_core wpg_checker u_wpg_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.cmd           (cmd),
	.result_valid  (result_valid),
	.current_phase (current_phase)
);
